/* rtl/rccs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and count helpers for the region class counter.
// No dependencies.
package rccs_pkg;

   localparam int COORD_W  = 9;
   localparam int CNT_W    = 17;
   localparam int CODE_W   = 8;

   localparam int MAX_ROWS_DEFAULT = 256;
   localparam int MAX_COLS_DEFAULT = 256;

   localparam logic [COORD_W-1:0] GRID_RESET = 9'd256;

   localparam logic [CODE_W-1:0] CODE_J = 8'h4A;
   localparam logic [CODE_W-1:0] CODE_O = 8'h4F;
   localparam logic [CODE_W-1:0] CODE_I = 8'h49;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic REG_GRID_ROWS = 1'b0;
   localparam logic REG_GRID_COLS = 1'b1;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      cnt_type count_i;
      cnt_type count_o;
      cnt_type count_j;
   } entry_type;

   typedef struct packed {
      logic                opcode;
      logic [CODE_W-1:0]   cell_code;
      logic [COORD_W-1:0]  top_row;
      logic [COORD_W-1:0]  left_col;
      logic [COORD_W-1:0]  bottom_row;
      logic [COORD_W-1:0]  right_col;
   } req_type;

   typedef struct packed {
      cnt_type count_j;
      cnt_type count_o;
      cnt_type count_i;
      logic    bad_rectangle;
   } rsp_type;

   function automatic entry_type ent_add(input entry_type a, input entry_type b);
      entry_type r;
      r.count_j = a.count_j + b.count_j;
      r.count_o = a.count_o + b.count_o;
      r.count_i = a.count_i + b.count_i;
      return r;
   endfunction

   function automatic entry_type ent_sub(input entry_type a, input entry_type b);
      entry_type r;
      r.count_j = a.count_j - b.count_j;
      r.count_o = a.count_o - b.count_o;
      r.count_i = a.count_i - b.count_i;
      return r;
   endfunction

endpackage

/* rtl/rccs_mem.sv */
`timescale 1ns / 1ps
// Prefix count store: one write port, two registered read ports.
// Depends on rccs_pkg for the entry type.
module rccs_mem import rccs_pkg::*; #(
   parameter int DEPTH  = MAX_ROWS_DEFAULT * MAX_COLS_DEFAULT,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output entry_type         rd_data_a,
   output entry_type         rd_data_b
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_a_ff;
   entry_type rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* rtl/region_class_count_sat.sv */
`timescale 1ns / 1ps
// Top level of the three-class summed-area table with its load/query sequencer.
// Depends on rccs_pkg and rccs_mem.
//
// Usage: req_* carries one item per handshake (req_valid high, req_stall low).
// A load item (opcode 0) writes the next cell in raster order; it gives no
// result. A query item (opcode 1) names a 1-based inclusive rectangle and
// gives one rsp_* item with the J, O and I counts, or bad_rectangle set and
// zero counts when the corners are inverted, zero or beyond the grid size.
// csr_wr_en writes grid_rows (index 0) or grid_cols (index 1) and restarts
// loading at the first cell; write only while the block is idle.
// Steps: a load reads the cell above, then writes the cell; a load past the
// end of the grid is accepted and dropped. A query makes two passes over the
// two read ports of the table memory and a summing step, then hands its
// result to the output step; a rejected rectangle goes straight to the
// output step. The block works on one item at a time and holds req_stall
// high meanwhile. Sizes beyond MAX_ROWS and MAX_COLS are clamped to them.
// rsp_* sits in an output register; while rsp_stall is high a finished item
// holds there and a further query waits before its result is written.
// Reset (synchronous, active high) restores both sizes to 256, clears the
// load position and drops rsp_valid. Table contents are not cleared; only
// entries written since reset may be queried.
module region_class_count_sat import rccs_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [COORD_W-1:0] csr_wr_data
);

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_CAP = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
   localparam int COL_CAP = (MAX_COLS > 511) ? 511 : MAX_COLS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_QRD_A = 3'd2;
   localparam logic [2:0] ST_QRD_B = 3'd3;
   localparam logic [2:0] ST_QSUM  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam logic [COORD_W-1:0] ONE = 9'd1;
   localparam logic [COORD_W-1:0] TWO = 9'd2;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r0,
                                                   input logic [COORD_W-1:0] c0);
      return ADDR_W'(r0) * ADDR_W'(MAX_COLS) + ADDR_W'(c0);
   endfunction

   logic [2:0]         state_ff, state_in;
   logic [COORD_W-1:0] grid_rows_ff, grid_rows_in;
   logic [COORD_W-1:0] grid_cols_ff, grid_cols_in;
   logic [COORD_W-1:0] load_row_ff, load_row_in;
   logic [COORD_W-1:0] load_col_ff, load_col_in;
   logic [COORD_W-1:0] top_ff, top_in;
   logic [COORD_W-1:0] left_ff, left_in;
   logic [COORD_W-1:0] bottom_ff, bottom_in;
   logic [COORD_W-1:0] right_ff, right_in;
   logic               top_one_ff, top_one_in;
   logic               left_one_ff, left_one_in;
   entry_type          hit_ff, hit_in;
   entry_type          prev_ff, prev_in;
   entry_type          diag_ff, diag_in;
   entry_type          part_ff, part_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [COORD_W-1:0] rows_eff;
   logic [COORD_W-1:0] cols_eff;
   logic               load_ok;
   logic               query_ok;
   entry_type          above;
   entry_type          new_entry;
   entry_type          zero_entry;

   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr_a;
   logic [ADDR_W-1:0]  mem_rd_addr_b;
   entry_type          mem_rd_data_a;
   entry_type          mem_rd_data_b;

   rccs_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (new_entry),
      .rd_en     (mem_rd_en),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   assign zero_entry = '0;
   assign rows_eff = (grid_rows_ff > COORD_W'(ROW_CAP)) ? COORD_W'(ROW_CAP) : grid_rows_ff;
   assign cols_eff = (grid_cols_ff > COORD_W'(COL_CAP)) ? COORD_W'(COL_CAP) : grid_cols_ff;

   assign load_ok = (rows_eff != '0) && (cols_eff != '0) &&
                    (load_row_ff < rows_eff) && (load_col_ff < cols_eff);

   assign query_ok = (req_data.top_row != '0) && (req_data.left_col != '0) &&
                     (req_data.top_row <= req_data.bottom_row) &&
                     (req_data.left_col <= req_data.right_col) &&
                     (req_data.bottom_row <= rows_eff) &&
                     (req_data.right_col <= cols_eff);

   // border: row 0 has nothing above, column 0 nothing to the left
   assign above     = (load_row_ff != '0) ? mem_rd_data_a : zero_entry;
   assign new_entry = ent_sub(ent_add(ent_add(hit_ff, above),
                                      (load_col_ff != '0) ? prev_ff : zero_entry),
                              (load_col_ff != '0) ? diag_ff : zero_entry);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      grid_rows_in  = grid_rows_ff;
      grid_cols_in  = grid_cols_ff;
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      top_in        = top_ff;
      left_in       = left_ff;
      bottom_in     = bottom_ff;
      right_in      = right_ff;
      top_one_in    = top_one_ff;
      left_one_in   = left_one_ff;
      hit_in        = hit_ff;
      prev_in       = prev_ff;
      diag_in       = diag_ff;
      part_in       = part_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = cell_addr(load_row_ff, load_col_ff);
      mem_rd_en     = 1'b0;
      mem_rd_addr_a = cell_addr(load_row_ff - ONE, load_col_ff);
      mem_rd_addr_b = cell_addr(top_ff - TWO, right_ff - ONE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == OP_LOAD) begin
                  if (load_ok) begin
                     hit_in.count_j = cnt_type'(req_data.cell_code == CODE_J);
                     hit_in.count_o = cnt_type'(req_data.cell_code == CODE_O);
                     hit_in.count_i = cnt_type'(req_data.cell_code == CODE_I);
                     mem_rd_en      = 1'b1;
                     state_in       = ST_LOAD;
                  end
               end else begin
                  top_in      = req_data.top_row;
                  left_in     = req_data.left_col;
                  bottom_in   = req_data.bottom_row;
                  right_in    = req_data.right_col;
                  top_one_in  = (req_data.top_row == ONE);
                  left_one_in = (req_data.left_col == ONE);
                  if (query_ok) begin
                     state_in = ST_QRD_A;
                  end else begin
                     res_in               = '0;
                     res_in.bad_rectangle = 1'b1;
                     state_in             = ST_OUT;
                  end
               end
            end
         end
         ST_LOAD: begin
            mem_wr_en = 1'b1;
            prev_in   = new_entry;
            diag_in   = above;
            if (load_col_ff + ONE >= cols_eff) begin
               load_col_in = '0;
               load_row_in = load_row_ff + ONE;
            end else begin
               load_col_in = load_col_ff + ONE;
            end
            state_in = ST_IDLE;
         end
         ST_QRD_A: begin
            mem_rd_en     = 1'b1;
            mem_rd_addr_a = cell_addr(bottom_ff - ONE, right_ff - ONE);
            mem_rd_addr_b = cell_addr(top_ff - TWO, right_ff - ONE);
            state_in      = ST_QRD_B;
         end
         ST_QRD_B: begin
            mem_rd_en     = 1'b1;
            mem_rd_addr_a = cell_addr(bottom_ff - ONE, left_ff - TWO);
            mem_rd_addr_b = cell_addr(top_ff - TWO, left_ff - TWO);
            part_in       = ent_sub(mem_rd_data_a, top_one_ff ? zero_entry : mem_rd_data_b);
            state_in      = ST_QSUM;
         end
         ST_QSUM: begin
            diag_in = diag_ff;
            begin
               entry_type sum;
               sum = ent_add(ent_sub(part_ff, left_one_ff ? zero_entry : mem_rd_data_a),
                             (top_one_ff || left_one_ff) ? zero_entry : mem_rd_data_b);
               res_in.count_j       = sum.count_j;
               res_in.count_o       = sum.count_o;
               res_in.count_i       = sum.count_i;
               res_in.bad_rectangle = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRID_ROWS: grid_rows_in = csr_wr_data;
            REG_GRID_COLS: grid_cols_in = csr_wr_data;
         endcase
         load_row_in = '0;
         load_col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grid_rows_ff <= GRID_RESET;
         grid_cols_ff <= GRID_RESET;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      left_ff     <= left_in;
      bottom_ff   <= bottom_in;
      right_ff    <= right_in;
      top_one_ff  <= top_one_in;
      left_one_ff <= left_one_in;
      hit_ff      <= hit_in;
      prev_ff     <= prev_in;
      diag_ff     <= diag_in;
      part_ff     <= part_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.bad_rectangle |->
         rsp_data_ff.count_j == '0 && rsp_data_ff.count_o == '0 &&
         rsp_data_ff.count_i == '0)
      else $error("rejected rectangle carries nonzero counts");

   a_col_in_grid: assert property (@(posedge clock) disable iff (reset)
      load_col_ff == '0 || load_col_ff < cols_eff)
      else $error("load column outside grid");

   a_sum_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QSUM |-> $past(state_ff) == ST_QRD_B)
      else $error("query sum without second read pass");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output step");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for region_class_count_sat: loads grids of cell codes in raster
// order, asks rectangle queries and checks each answer against a summed-area table kept here.
// Depends on rccs_pkg and the region_class_count_sat RTL.
module testbench;
   import rccs_pkg::*;

   localparam int ROWS_MAX    = MAX_ROWS_DEFAULT;
   localparam int COLS_MAX    = MAX_COLS_DEFAULT;
   localparam int CLASS_J     = 0;
   localparam int CLASS_O     = 1;
   localparam int CLASS_I     = 2;
   localparam int ITEM_TARGET = 1700;
   localparam int SETTLE      = 8;
   localparam int IDLE_LIMIT  = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en = 1'b0;
   logic               csr_index = REG_GRID_ROWS;
   logic [COORD_W-1:0] csr_wr_data = '0;

   cnt_type            sat_table [0:ROWS_MAX*COLS_MAX-1][0:2];
   bit                 sat_written [0:ROWS_MAX*COLS_MAX-1];
   logic [COORD_W-1:0] rows_set = GRID_RESET;
   logic [COORD_W-1:0] cols_set = GRID_RESET;
   int                 next_row = 0;
   int                 next_col = 0;

   rsp_type            pending_counts [$];
   int                 errors = 0;
   int                 idle_cycles = 0;
   int                 items_sent = 0;
   int                 burst_left = 0;
   int                 stall_mode = 0;
   int                 stall_left = 0;

   region_class_count_sat uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int used_rows();
      return (rows_set > ROWS_MAX) ? ROWS_MAX : int'(rows_set);
   endfunction

   function automatic int used_cols();
      return (cols_set > COLS_MAX) ? COLS_MAX : int'(cols_set);
   endfunction

   function automatic cnt_type sat_at(input int r, input int c, input int k);
      if (r == 0 || c == 0) return '0;
      return sat_table[(r - 1) * COLS_MAX + c - 1][k];
   endfunction

   function automatic bit sat_known(input int r, input int c);
      return (r == 0 || c == 0) ? 1'b1 : sat_written[(r - 1) * COLS_MAX + c - 1];
   endfunction

   function automatic bit class_hit(input logic [CODE_W-1:0] code, input int k);
      case (k)
         CLASS_J: return code == CODE_J;
         CLASS_O: return code == CODE_O;
         default: return code == CODE_I;
      endcase
   endfunction

   function automatic bit sat_load(input logic [CODE_W-1:0] code);
      int      r, c, k;
      cnt_type hit;
      if (used_rows() == 0 || used_cols() == 0 || next_row >= used_rows()
          || next_col >= used_cols())
         return 1'b0;
      r = next_row + 1;
      c = next_col + 1;
      for (k = 0; k < 3; k++) begin
         hit = class_hit(code, k) ? cnt_type'(1) : cnt_type'(0);
         sat_table[next_row * COLS_MAX + next_col][k] =
            hit + sat_at(r - 1, c, k) + sat_at(r, c - 1, k) - sat_at(r - 1, c - 1, k);
      end
      sat_written[next_row * COLS_MAX + next_col] = 1'b1;
      next_col++;
      if (next_col >= used_cols()) begin
         next_col = 0;
         next_row++;
      end
      return 1'b1;
   endfunction

   function automatic bit rect_in_grid(input logic [COORD_W-1:0] t_row, l_col, b_row, r_col);
      return t_row >= 1 && l_col >= 1 && t_row <= b_row && l_col <= r_col
         && b_row <= used_rows() && r_col <= used_cols();
   endfunction

   function automatic bit query_readable(input logic [COORD_W-1:0] t_row, l_col, b_row, r_col);
      return rect_in_grid(t_row, l_col, b_row, r_col)
         && sat_known(b_row, r_col) && sat_known(t_row - 1, r_col)
         && sat_known(b_row, l_col - 1) && sat_known(t_row - 1, l_col - 1);
   endfunction

   function automatic rsp_type rect_counts(input req_type q);
      rsp_type res;
      cnt_type sum [0:2];
      int      k;
      res = '0;
      if (!rect_in_grid(q.top_row, q.left_col, q.bottom_row, q.right_col)) begin
         res.bad_rectangle = 1'b1;
         return res;
      end
      for (k = 0; k < 3; k++)
         sum[k] = sat_at(q.bottom_row, q.right_col, k) - sat_at(q.top_row - 1, q.right_col, k)
            - sat_at(q.bottom_row, q.left_col - 1, k)
            + sat_at(q.top_row - 1, q.left_col - 1, k);
      res.count_j = sum[CLASS_J];
      res.count_o = sum[CLASS_O];
      res.count_i = sum[CLASS_I];
      return res;
   endfunction

   function automatic logic [CODE_W-1:0] random_code();
      case ($urandom_range(7, 0))
         0, 1:    return CODE_J;
         2, 3:    return CODE_O;
         4, 5:    return CODE_I;
         default: return CODE_W'($urandom_range(255, 0));
      endcase
   endfunction

   task automatic send_item(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
      if (item.opcode == OP_QUERY) begin
         pending_counts = {pending_counts, rect_counts(item)};
         items_sent++;
      end else if (sat_load(item.cell_code)) begin
         items_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = $urandom_range(40, 0);
      end
   endtask

   task automatic send_load(input logic [CODE_W-1:0] code);
      req_type item;
      item.opcode     = OP_LOAD;
      item.cell_code  = code;
      item.top_row    = COORD_W'($urandom_range(511, 0));
      item.left_col   = COORD_W'($urandom_range(511, 0));
      item.bottom_row = COORD_W'($urandom_range(511, 0));
      item.right_col  = COORD_W'($urandom_range(511, 0));
      send_item(item);
   endtask

   task automatic send_query(input logic [COORD_W-1:0] t_row, l_col, b_row, r_col);
      req_type item;
      item.opcode     = OP_QUERY;
      item.cell_code  = CODE_W'($urandom_range(255, 0));
      item.top_row    = t_row;
      item.left_col   = l_col;
      item.bottom_row = b_row;
      item.right_col  = r_col;
      send_item(item);
   endtask

   task automatic send_random_query();
      logic [COORD_W-1:0] t_row, l_col, b_row, r_col;
      int                 tries;
      bit                 found;
      found = 1'b0;
      if ($urandom_range(5, 0) != 0 && used_rows() > 0 && used_cols() > 0) begin
         for (tries = 0; tries < 16 && !found; tries++) begin
            b_row = COORD_W'($urandom_range(used_rows(), 1));
            r_col = COORD_W'($urandom_range(used_cols(), 1));
            t_row = COORD_W'($urandom_range(b_row, 1));
            l_col = COORD_W'($urandom_range(r_col, 1));
            found = query_readable(t_row, l_col, b_row, r_col);
         end
      end
      if (!found) begin
         t_row = COORD_W'($urandom_range(511, 0));
         l_col = COORD_W'($urandom_range(511, 0));
         b_row = COORD_W'($urandom_range(511, 0));
         r_col = COORD_W'($urandom_range(511, 0));
         case ($urandom_range(4, 0))
            0: t_row = '0;
            1: l_col = '0;
            2: b_row = COORD_W'(used_rows() + 1);
            3: r_col = COORD_W'(used_cols() + 1);
            default: begin
               b_row = COORD_W'($urandom_range(510, 0));
               t_row = COORD_W'(b_row + 1);
            end
         endcase
         if (rect_in_grid(t_row, l_col, b_row, r_col)) t_row = '0;
      end
      send_query(t_row, l_col, b_row, r_col);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_size(input logic index, input logic [COORD_W-1:0] value);
      wait_idle();
      csr_index   <= index;
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == REG_GRID_ROWS) rows_set = value;
      else cols_set = value;
      next_row = 0;
      next_col = 0;
   endtask

   task automatic set_grid(input logic [COORD_W-1:0] rows, cols);
      if ($urandom_range(1, 0) == 0) begin
         write_size(REG_GRID_ROWS, rows);
         write_size(REG_GRID_COLS, cols);
      end else begin
         write_size(REG_GRID_COLS, cols);
         write_size(REG_GRID_ROWS, rows);
      end
   endtask

   task automatic test_reset_sizes();
      send_load(CODE_J);
      send_load(CODE_O);
      send_load(CODE_I);
      send_query(1, 1, 1, 3);
      send_query(1, 2, 1, 2);
      send_query(1, 1, 257, 1);
      send_query(1, 1, 1, 257);
   endtask

   task automatic test_small_grid();
      set_grid(2, 3);
      send_load(CODE_J);
      send_load(8'h41);
      send_load(CODE_O);
      send_load(8'hFF);
      send_load(CODE_I);
      send_load(8'h00);
      send_load(CODE_J);
      send_load(CODE_I);
      send_query(1, 1, 2, 3);
      send_query(2, 2, 2, 3);
      send_query(3, 1, 3, 1);
      send_query(1, 4, 1, 4);
      send_query(0, 1, 1, 1);
      send_query(2, 1, 1, 1);
      send_query(1, 3, 1, 2);
      send_query(511, 511, 511, 511);
   endtask

   task automatic test_zero_size();
      set_grid(0, 5);
      send_load(CODE_J);
      send_query(1, 1, 1, 1);
      set_grid(4, 0);
      send_load(CODE_O);
      send_query(1, 1, 1, 1);
   endtask

   task automatic test_full_span_shapes();
      int n;
      set_grid(511, 1);
      for (n = 0; n < ROWS_MAX; n++) begin
         send_load(random_code());
         if ($urandom_range(7, 0) == 0) send_random_query();
      end
      send_query(1, 1, 256, 1);
      repeat (20) send_random_query();
      set_grid(1, 511);
      for (n = 0; n < COLS_MAX; n++) begin
         send_load(random_code());
         if ($urandom_range(7, 0) == 0) send_random_query();
      end
      send_query(1, 1, 1, 256);
      repeat (20) send_random_query();
   endtask

   task automatic test_random_grids();
      int new_rows, new_cols, loads, n;
      bit paused;
      paused = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(15, 0))
            0: begin
               new_rows = 0;
               new_cols = $urandom_range(511, 0);
            end
            1: begin
               new_rows = $urandom_range(511, 0);
               new_cols = 0;
            end
            2: begin
               new_rows = $urandom_range(511, 100);
               new_cols = $urandom_range(2, 1);
            end
            3: begin
               new_rows = $urandom_range(2, 1);
               new_cols = $urandom_range(511, 100);
            end
            default: begin
               new_rows = $urandom_range(12, 1);
               new_cols = $urandom_range(12, 1);
            end
         endcase
         set_grid(COORD_W'(new_rows), COORD_W'(new_cols));
         loads = used_rows() * used_cols();
         if ($urandom_range(3, 0) == 0) loads = int'($urandom_range(loads, 0));
         else loads += $urandom_range(3, 0);
         for (n = 0; n < loads; n++) begin
            send_load(random_code());
            if ($urandom_range(3, 0) == 0) send_random_query();
         end
         if (!paused || $urandom_range(3, 0) == 0) begin
            wait_idle();
            paused = 1'b1;
         end
         repeat ($urandom_range(30, 8)) begin
            if ($urandom_range(7, 0) == 0) send_load(random_code());
            else send_random_query();
         end
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(2, 0);
         stall_left <= $urandom_range(60, 10);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(3, 0) == 0);
         default: rsp_stall <= ($urandom_range(3, 0) != 0);
      endcase
   end

   always @(posedge clock) begin : check_result
      rsp_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_counts.size() == 0) begin
               $error("result with no query outstanding");
               errors++;
            end else begin
               want = pending_counts.pop_front();
               check_field("count_j", int'(want.count_j), int'(rsp_data.count_j));
               check_field("count_o", int'(want.count_o), int'(rsp_data.count_o));
               check_field("count_i", int'(want.count_i), int'(rsp_data.count_i));
               check_field("bad_rectangle", int'(want.bad_rectangle),
                           int'(rsp_data.bad_rectangle));
            end
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_sizes();
      test_small_grid();
      test_zero_size();
      test_full_span_shapes();
      test_random_grids();
      wait_idle();
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

/* files.f */
rtl/rccs_pkg.sv
rtl/rccs_mem.sv
rtl/region_class_count_sat.sv
tb/testbench.sv
